// File: sv/kma_pkg.sv
// Shared types and constants of the two-dimensional k-means engine.
`timescale 1ns / 1ps

package kma_pkg;

   localparam int OPCODE_W    = 2;
   localparam int COORD_IN_W  = 11;
   localparam int INDEX_W     = 4;
   localparam int ID_W        = 4;
   localparam int DIST_OUT_W  = 23;
   localparam int COORD_OUT_W = 11;
   localparam int COUNT_OUT_W = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ASSIGN = 2'd0,
      OP_UPDATE = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_X,
      ST_SCAN_Y,
      ST_SCAN_CMP,
      ST_ACC,
      ST_READ,
      ST_UPD_LOAD,
      ST_UPD_DIVX,
      ST_UPD_DIVY,
      ST_UPD_WRITE,
      ST_EMIT
   } state_type;

endpackage

// File: sv/kma_req_if.sv
// Request channel: opcode, point and centroid index with valid/ready.
`timescale 1ns / 1ps

interface kma_req_if;
   import kma_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [COORD_IN_W-1:0] point_x;
   logic [COORD_IN_W-1:0] point_y;
   logic [INDEX_W-1:0]    cluster_index;

   modport source (output valid, opcode, point_x, point_y, cluster_index, input ready);
   modport sink   (input valid, opcode, point_x, point_y, cluster_index, output ready);
endinterface

// File: sv/kma_rsp_if.sv
// Response channel: nearest or read centroid, distance, count and flag.
`timescale 1ns / 1ps

interface kma_rsp_if;
   import kma_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ID_W-1:0]        cluster_id;
   logic [DIST_OUT_W-1:0]  sq_distance;
   logic [COORD_OUT_W-1:0] centroid_x;
   logic [COORD_OUT_W-1:0] centroid_y;
   logic [COUNT_OUT_W-1:0] member_count;
   logic                   count_saturated;

   modport source (output valid, cluster_id, sq_distance, centroid_x, centroid_y,
                   member_count, count_saturated, input ready);
   modport sink   (input valid, cluster_id, sq_distance, centroid_x, centroid_y,
                   member_count, count_saturated, output ready);
endinterface

// File: sv/kma_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module kma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/kmeans_assign_update.sv
// Top level of the two-dimensional k-means engine.
`timescale 1ns / 1ps

// Holds CLUSTERS centroids with per-cluster coordinate sums and member counts in two
// small RAMs, and works one request beat at a time; req_ch is ready only while idle.
// After reset a clearing pass loads centroid i with (i,i) and zero sums and counts;
// no request is taken meanwhile. Assign visits every centroid through one shared
// squarer, one centroid at a time (dx squared, dy squared, add and compare, lowest
// index wins ties), then accumulates the point into the nearest cluster. Update runs
// one restoring divider a bit per cycle, x then y, for each non-empty cluster and
// skips empty clusters. Read goes through ST_READ; the unused opcode and an out-of-
// range read index go straight to ST_EMIT. A full count drops the point and raises
// count_saturated. The response sits in an output register, so the next request is
// accepted while it waits to be taken.
module kmeans_assign_update #(
   parameter int CLUSTERS   = 16,
   parameter int COORD_BITS = 11,
   parameter int COUNT_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   kma_req_if.sink    req_ch,
   kma_rsp_if.source  rsp_ch
);
   import kma_pkg::*;

   localparam int CIDX_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int SUM_W  = COORD_BITS + COUNT_BITS;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 1;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int CTR_W  = 2 * COORD_BITS;
   localparam int ACC_W  = 2 * SUM_W + COUNT_BITS;
   localparam logic [CIDX_W-1:0]     LAST_IDX  = CIDX_W'(CLUSTERS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(SUM_W - 1);

   state_type state_ff, state_in;
   logic [CIDX_W-1:0]     cidx_ff, cidx_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [SQ_W-1:0]       prod_ff, prod_in, sqx_ff, sqx_in;
   logic [DIST_W-1:0]     best_d_ff, best_d_in;
   logic [CIDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [COORD_BITS-1:0] best_cx_ff, best_cx_in, best_cy_ff, best_cy_in;
   logic [SUM_W-1:0]      dvd_ff, dvd_in, sumy_ff, sumy_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in, divisor_ff, divisor_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COORD_BITS-1:0] qx_ff, qx_in;

   logic [ID_W-1:0]        res_id_ff, res_id_in;
   logic [DIST_OUT_W-1:0]  res_dist_ff, res_dist_in;
   logic [COORD_OUT_W-1:0] res_cx_ff, res_cx_in, res_cy_ff, res_cy_in;
   logic [COUNT_OUT_W-1:0] res_count_ff, res_count_in;
   logic                   res_sat_ff, res_sat_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [DIST_OUT_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [COORD_OUT_W-1:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic                  ctr_we, acc_we;
   logic [CTR_W-1:0]      ctr_wd, ctr_rd;
   logic [ACC_W-1:0]      acc_wd, acc_rd;
   logic [COORD_BITS-1:0] ctr_cx, ctr_cy;
   logic [SUM_W-1:0]      acc_sx, acc_sy, sx_add, sy_add;
   logic [COUNT_BITS-1:0] acc_cnt, cnt_inc;

   logic [COORD_BITS-1:0] sq_a, sq_b, sq_op;
   logic [SQ_W-1:0]       sq_prod;
   logic [DIST_W-1:0]     dist_sum;
   logic                  upd_best;

   logic [COUNT_BITS:0]   rem_sh, rem_diff;
   logic                  fits, step_done;
   logic [COUNT_BITS-1:0] rem_next;
   logic [SUM_W-1:0]      dvd_next;
   logic                  idx_in_range;

   kma_ram #(.WIDTH(CTR_W), .DEPTH(CLUSTERS)) u_ctr_ram (
      .clock   (clock),
      .wr_en   (ctr_we),
      .wr_addr (cidx_ff),
      .wr_data (ctr_wd),
      .rd_addr (cidx_in),
      .rd_data (ctr_rd)
   );

   kma_ram #(.WIDTH(ACC_W), .DEPTH(CLUSTERS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (cidx_ff),
      .wr_data (acc_wd),
      .rd_addr (cidx_in),
      .rd_data (acc_rd)
   );

   assign ctr_cx  = ctr_rd[CTR_W-1 -: COORD_BITS];
   assign ctr_cy  = ctr_rd[COORD_BITS-1:0];
   assign acc_sx  = acc_rd[ACC_W-1 -: SUM_W];
   assign acc_sy  = acc_rd[COUNT_BITS +: SUM_W];
   assign acc_cnt = acc_rd[COUNT_BITS-1:0];
   assign sx_add  = acc_sx + SUM_W'(px_ff);
   assign sy_add  = acc_sy + SUM_W'(py_ff);
   assign cnt_inc = acc_cnt + 1'b1;

   // shared squarer: x difference in the first scan cycle, y in the second
   assign sq_a    = (state_ff == ST_SCAN_X) ? px_ff  : py_ff;
   assign sq_b    = (state_ff == ST_SCAN_X) ? ctr_cx : ctr_cy;
   assign sq_op   = (sq_a >= sq_b) ? (sq_a - sq_b) : (sq_b - sq_a);
   assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);
   assign dist_sum = DIST_W'(sqx_ff) + DIST_W'(prod_ff);
   assign upd_best = (cidx_ff == '0) || (dist_sum < best_d_ff);

   // restoring divider, one quotient bit a cycle
   assign rem_sh    = {rem_ff, dvd_ff[SUM_W-1]};
   assign rem_diff  = rem_sh - {1'b0, divisor_ff};
   assign fits      = rem_sh >= {1'b0, divisor_ff};
   assign rem_next  = fits ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
   assign dvd_next  = {dvd_ff[SUM_W-2:0], fits};
   assign step_done = (step_ff == LAST_STEP);

   assign idx_in_range = 32'(req_ch.cluster_index) < 32'(CLUSTERS);

   always_comb begin
      state_in     = state_ff;
      cidx_in      = cidx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      prod_in      = prod_ff;
      sqx_in       = sqx_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      best_cx_in   = best_cx_ff;
      best_cy_in   = best_cy_ff;
      dvd_in       = dvd_ff;
      sumy_in      = sumy_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      qx_in        = qx_ff;
      res_id_in    = res_id_ff;
      res_dist_in  = res_dist_ff;
      res_cx_in    = res_cx_ff;
      res_cy_in    = res_cy_ff;
      res_count_in = res_count_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sat_in   = rsp_sat_ff;
      req_ch.ready = 1'b0;
      ctr_we       = 1'b0;
      ctr_wd       = '0;
      acc_we       = 1'b0;
      acc_wd       = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ctr_we = 1'b1;
            ctr_wd = {COORD_BITS'(cidx_ff), COORD_BITS'(cidx_ff)};
            acc_we = 1'b1;
            if (cidx_ff == LAST_IDX) begin
               cidx_in  = '0;
               state_in = ST_IDLE;
            end else begin
               cidx_in = cidx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               px_in        = COORD_BITS'(req_ch.point_x);
               py_in        = COORD_BITS'(req_ch.point_y);
               cidx_in      = '0;
               res_id_in    = '0;
               res_dist_in  = '0;
               res_cx_in    = '0;
               res_cy_in    = '0;
               res_count_in = '0;
               res_sat_in   = 1'b0;
               priority if (req_ch.opcode == OP_ASSIGN) begin
                  state_in = ST_SCAN_X;
               end else if (req_ch.opcode == OP_UPDATE) begin
                  state_in = ST_UPD_LOAD;
               end else if (req_ch.opcode == OP_READ) begin
                  res_id_in = ID_W'(req_ch.cluster_index);
                  if (idx_in_range) begin
                     cidx_in  = CIDX_W'(req_ch.cluster_index);
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN_X: begin
            prod_in  = sq_prod;
            state_in = ST_SCAN_Y;
         end
         ST_SCAN_Y: begin
            sqx_in   = prod_ff;
            prod_in  = sq_prod;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (upd_best) begin
               best_d_in   = dist_sum;
               best_idx_in = cidx_ff;
               best_cx_in  = ctr_cx;
               best_cy_in  = ctr_cy;
            end
            if (cidx_ff == LAST_IDX) begin
               cidx_in  = upd_best ? cidx_ff : best_idx_ff;
               state_in = ST_ACC;
            end else begin
               cidx_in  = cidx_ff + 1'b1;
               state_in = ST_SCAN_X;
            end
         end
         ST_ACC: begin
            res_id_in   = ID_W'(best_idx_ff);
            res_dist_in = DIST_OUT_W'(best_d_ff);
            res_cx_in   = COORD_OUT_W'(best_cx_ff);
            res_cy_in   = COORD_OUT_W'(best_cy_ff);
            if (acc_cnt == COUNT_MAX) begin
               res_sat_in   = 1'b1;
               res_count_in = COUNT_OUT_W'(acc_cnt);
            end else begin
               acc_we       = 1'b1;
               acc_wd       = {sx_add, sy_add, cnt_inc};
               res_count_in = COUNT_OUT_W'(cnt_inc);
            end
            state_in = ST_EMIT;
         end
         ST_READ: begin
            res_cx_in    = COORD_OUT_W'(ctr_cx);
            res_cy_in    = COORD_OUT_W'(ctr_cy);
            res_count_in = COUNT_OUT_W'(acc_cnt);
            state_in     = ST_EMIT;
         end
         ST_UPD_LOAD: begin
            if (acc_cnt == '0) begin
               if (cidx_ff == LAST_IDX) begin
                  state_in = ST_EMIT;
               end else begin
                  cidx_in = cidx_ff + 1'b1;
               end
            end else begin
               dvd_in     = acc_sx;
               sumy_in    = acc_sy;
               divisor_in = acc_cnt;
               rem_in     = '0;
               step_in    = '0;
               state_in   = ST_UPD_DIVX;
            end
         end
         ST_UPD_DIVX: begin
            dvd_in  = dvd_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (step_done) begin
               qx_in    = dvd_next[COORD_BITS-1:0];
               dvd_in   = sumy_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_UPD_DIVY;
            end
         end
         ST_UPD_DIVY: begin
            dvd_in  = dvd_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (step_done) begin
               state_in = ST_UPD_WRITE;
            end
         end
         ST_UPD_WRITE: begin
            ctr_we = 1'b1;
            ctr_wd = {qx_ff, dvd_ff[COORD_BITS-1:0]};
            acc_we = 1'b1;
            if (cidx_ff == LAST_IDX) begin
               state_in = ST_EMIT;
            end else begin
               cidx_in  = cidx_ff + 1'b1;
               state_in = ST_UPD_LOAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_dist_in  = res_dist_ff;
               rsp_cx_in    = res_cx_ff;
               rsp_cy_in    = res_cy_ff;
               rsp_count_in = res_count_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cidx_ff      <= cidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      prod_ff      <= prod_in;
      sqx_ff       <= sqx_in;
      best_d_ff    <= best_d_in;
      best_idx_ff  <= best_idx_in;
      best_cx_ff   <= best_cx_in;
      best_cy_ff   <= best_cy_in;
      dvd_ff       <= dvd_in;
      sumy_ff      <= sumy_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      qx_ff        <= qx_in;
      res_id_ff    <= res_id_in;
      res_dist_ff  <= res_dist_in;
      res_cx_ff    <= res_cx_in;
      res_cy_ff    <= res_cy_in;
      res_count_ff <= res_count_in;
      res_sat_ff   <= res_sat_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.cluster_id      = rsp_id_ff;
   assign rsp_ch.sq_distance     = rsp_dist_ff;
   assign rsp_ch.centroid_x      = rsp_cx_ff;
   assign rsp_ch.centroid_y      = rsp_cy_ff;
   assign rsp_ch.member_count    = rsp_count_ff;
   assign rsp_ch.count_saturated = rsp_sat_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside emit");

   a_sat_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.count_saturated |->
         rsp_ch.member_count == COUNT_OUT_W'(COUNT_MAX))
      else $error("saturation flagged without a full count");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_DIVX || state_ff == ST_UPD_DIVY) |-> step_ff <= LAST_STEP)
      else $error("divider ran past its last step");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ctr_we && !acc_we)
      else $error("store written while idle");
endmodule
